/* sv/pal_pkg.sv */
// Shared types and constants of the positional array list engine.
// Used by the front decoder, the command queue, the back engine and the top level.
// Depends on nothing.
package pal_pkg;

   localparam int unsigned CMD_W   = 3;
   localparam int unsigned POS_W   = 6;
   localparam int unsigned DATA_W  = 32;
   localparam int unsigned STAT_W  = 2;

   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DELETE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_GET    = 3'd2;
   localparam logic [CMD_W-1:0] CMD_LOCATE = 3'd3;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
   localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

   localparam int unsigned CMDQ_DEPTH = 2;
   localparam int unsigned CMDQ_AW    = 1;

   typedef struct packed {
      logic [CMD_W-1:0]         command;
      logic [POS_W-1:0]         position;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic signed [DATA_W-1:0] read_value;
      logic [POS_W-1:0]         found_position;
      logic [POS_W-1:0]         list_size;
   } rsp_type;

   typedef enum logic [2:0] {
      OP_INSERT,
      OP_DELETE,
      OP_GET,
      OP_LOCATE,
      OP_CLEAR,
      OP_BAD
   } op_type;

   typedef struct packed {
      op_type             op;
      logic [POS_W-1:0]   position;
      logic [DATA_W-1:0]  value;
   } cmd_type;

   typedef enum logic {
      BK_IDLE,
      BK_RUN
   } bk_state_type;

endpackage

/* sv/pal_front.sv */
// Front decoder: accepts request beats and turns each into a classified command.
// Depends on pal_pkg; feeds pal_cmdq.
module pal_front (
   input  logic             req_push,
   output logic             req_full,
   input  pal_pkg::req_type req_data,
   output logic             cq_push,
   input  logic             cq_full,
   output pal_pkg::cmd_type cq_data
);
   import pal_pkg::*;

   assign req_full = cq_full;
   assign cq_push  = req_push & ~cq_full;

   always_comb begin
      cq_data.position = req_data.position;
      cq_data.value    = req_data.value;
      unique case (req_data.command)
         CMD_INSERT: cq_data.op = OP_INSERT;
         CMD_DELETE: cq_data.op = OP_DELETE;
         CMD_GET:    cq_data.op = OP_GET;
         CMD_LOCATE: cq_data.op = OP_LOCATE;
         CMD_CLEAR:  cq_data.op = OP_CLEAR;
         default:    cq_data.op = OP_BAD;
      endcase
   end

endmodule

/* sv/pal_cmdq.sv */
// Short command queue between the front decoder and the back engine.
// Depends on pal_pkg.
module pal_cmdq (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   output logic             full,
   input  pal_pkg::cmd_type push_data,
   input  logic             pop,
   output logic             empty,
   output pal_pkg::cmd_type pop_data
);
   import pal_pkg::*;

   cmd_type            q_ff [CMDQ_DEPTH];
   logic [CMDQ_AW:0]   wptr_ff;
   logic [CMDQ_AW:0]   wptr_in;
   logic [CMDQ_AW:0]   rptr_ff;
   logic [CMDQ_AW:0]   rptr_in;
   logic               do_push;
   logic               do_pop;

   assign empty = (wptr_ff == rptr_ff);
   assign full  = (wptr_ff[CMDQ_AW] != rptr_ff[CMDQ_AW]) &&
                  (wptr_ff[CMDQ_AW-1:0] == rptr_ff[CMDQ_AW-1:0]);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = q_ff[rptr_ff[CMDQ_AW-1:0]];
   assign wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
   assign rptr_in  = do_pop ? rptr_ff + 1'b1 : rptr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         q_ff[wptr_ff[CMDQ_AW-1:0]] <= push_data;
      end
   end

endmodule

/* sv/pal_back.sv */
// Back engine: holds the element memory and the length, shifts, reads and scans
// entries one per cycle, and keeps the result register. Depends on pal_pkg.
module pal_back #(
   parameter int unsigned CAPACITY = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cq_empty,
   output logic             cq_pop,
   input  pal_pkg::cmd_type cq_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output pal_pkg::rsp_type rsp_data
);
   import pal_pkg::*;

   localparam int unsigned AW = $clog2(CAPACITY);
   localparam int unsigned CW = $clog2(CAPACITY + 1);
   localparam int unsigned XW = ((CW > POS_W) ? CW : POS_W) + 1;

   logic [DATA_W-1:0] mem [CAPACITY];
   logic [DATA_W-1:0] rdata_ff;

   bk_state_type      state_ff, state_in;
   logic [CW-1:0]     count_ff, count_in;
   op_type            op_ff, op_in;
   logic [AW-1:0]     addr_ff, addr_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic [AW-1:0]     ptr_ff, ptr_in;
   logic [CW-1:0]     rem_ff, rem_in;
   logic              first_ff, first_in;
   logic              pend_ff, pend_in;
   logic              pend_cap_ff, pend_cap_in;
   logic [AW-1:0]     pend_addr_ff, pend_addr_in;
   logic [DATA_W-1:0] rdval_ff, rdval_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_ff, out_in;

   logic              out_load;
   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [DATA_W-1:0] wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [XW-1:0]     p_x;
   logic [XW-1:0]     n_x;
   logic              pos_bad;
   logic              ins_bad;
   logic              is_full;
   logic              match;

   assign rsp_empty = ~out_valid_ff;
   assign rsp_data  = out_ff;
   assign p_x       = XW'(cq_data.position);
   assign n_x       = XW'(count_ff);
   assign is_full   = (n_x >= XW'(CAPACITY));
   assign pos_bad   = (p_x == '0) || (p_x > n_x);
   assign ins_bad   = (p_x == '0) || (p_x > n_x + XW'(1));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      value_in     = value_ff;
      ptr_in       = ptr_ff;
      rem_in       = rem_ff;
      first_in     = first_ff;
      pend_in      = 1'b0;
      pend_cap_in  = pend_cap_ff;
      pend_addr_in = pend_addr_ff;
      rdval_in     = rdval_ff;
      out_in       = out_ff;
      out_load     = 1'b0;
      cq_pop       = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = value_ff;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff;
      match        = 1'b0;

      unique case (state_ff)
         BK_IDLE: begin
            if (!cq_empty && !out_valid_ff) begin
               cq_pop   = 1'b1;
               op_in    = cq_data.op;
               value_in = cq_data.value;
               addr_in  = AW'(p_x - XW'(1));
               out_in   = '{status: ST_MISS, read_value: '0, found_position: '0,
                            list_size: POS_W'(count_ff)};
               unique case (cq_data.op)
                  OP_INSERT: begin
                     if (is_full) begin
                        out_in.status = ST_FULL;
                        out_load      = 1'b1;
                     end else if (ins_bad) begin
                        out_load = 1'b1;
                     end else begin
                        rem_in   = CW'(n_x - p_x + XW'(1));
                        ptr_in   = AW'(n_x - XW'(1));
                        first_in = 1'b0;
                        state_in = BK_RUN;
                     end
                  end
                  OP_DELETE: begin
                     if (pos_bad) begin
                        out_load = 1'b1;
                     end else begin
                        rem_in   = CW'(n_x - p_x + XW'(1));
                        ptr_in   = AW'(p_x - XW'(1));
                        first_in = 1'b1;
                        state_in = BK_RUN;
                     end
                  end
                  OP_GET: begin
                     if (pos_bad) begin
                        out_load = 1'b1;
                     end else begin
                        rem_in   = CW'(1);
                        ptr_in   = AW'(p_x - XW'(1));
                        first_in = 1'b1;
                        state_in = BK_RUN;
                     end
                  end
                  OP_LOCATE: begin
                     rem_in   = count_ff;
                     ptr_in   = '0;
                     first_in = 1'b0;
                     state_in = BK_RUN;
                  end
                  OP_CLEAR: begin
                     count_in         = '0;
                     out_in.status    = ST_OK;
                     out_in.list_size = '0;
                     out_load         = 1'b1;
                  end
                  default: begin
                     out_load = 1'b1;
                  end
               endcase
            end
         end
         BK_RUN: begin
            if (pend_ff) begin
               unique case (op_ff)
                  OP_INSERT: begin
                     wr_en   = 1'b1;
                     wr_addr = pend_addr_ff + AW'(1);
                     wr_data = rdata_ff;
                  end
                  OP_DELETE: begin
                     if (pend_cap_ff) begin
                        rdval_in = rdata_ff;
                     end else begin
                        wr_en   = 1'b1;
                        wr_addr = pend_addr_ff - AW'(1);
                        wr_data = rdata_ff;
                     end
                  end
                  OP_GET: begin
                     rdval_in = rdata_ff;
                  end
                  OP_LOCATE: begin
                     match = (rdata_ff == value_ff);
                  end
                  default: begin
                  end
               endcase
            end
            if (match) begin
               out_in = '{status: ST_OK, read_value: '0,
                          found_position: POS_W'({1'b0, pend_addr_ff} + (AW + 1)'(1)),
                          list_size: POS_W'(count_ff)};
               out_load = 1'b1;
               state_in = BK_IDLE;
            end else if (rem_ff != '0) begin
               rd_en        = 1'b1;
               pend_in      = 1'b1;
               pend_addr_in = ptr_ff;
               pend_cap_in  = first_ff;
               first_in     = 1'b0;
               rem_in       = rem_ff - CW'(1);
               ptr_in       = (op_ff == OP_INSERT) ? ptr_ff - AW'(1) : ptr_ff + AW'(1);
            end else if (!pend_ff) begin
               out_in   = '{status: ST_OK, read_value: '0, found_position: '0,
                            list_size: POS_W'(count_ff)};
               out_load = 1'b1;
               state_in = BK_IDLE;
               unique case (op_ff)
                  OP_INSERT: begin
                     wr_en            = 1'b1;
                     wr_addr          = addr_ff;
                     wr_data          = value_ff;
                     count_in         = count_ff + CW'(1);
                     out_in.list_size = POS_W'(count_ff + CW'(1));
                  end
                  OP_DELETE: begin
                     count_in          = count_ff - CW'(1);
                     out_in.read_value = rdval_ff;
                     out_in.list_size  = POS_W'(count_ff - CW'(1));
                  end
                  OP_GET: begin
                     out_in.read_value = rdval_ff;
                  end
                  default: begin
                     out_in.status = ST_MISS;
                  end
               endcase
            end
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase

      out_valid_in = (out_valid_ff & ~rsp_pop) | out_load;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      addr_ff      <= addr_in;
      value_ff     <= value_in;
      ptr_ff       <= ptr_in;
      rem_ff       <= rem_in;
      first_ff     <= first_in;
      pend_cap_ff  <= pend_cap_in;
      pend_addr_ff <= pend_addr_in;
      rdval_ff     <= rdval_in;
      out_ff       <= out_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

endmodule

/* sv/positional_array_list_engine.sv */
// Ordered list of signed 32-bit values with insert, delete, get, locate and clear commands.
// A rejected command or a clear is answered from the idle state; every other command
// goes through the run state: insert shifts the entries from the end toward the position
// and writes the new value, delete reads the removed entry and moves each later entry
// forward, get reads one entry, and locate scans from the front until the first match.
// The element memory reads one entry per cycle while the shifted entry before it is
// written back. A two-entry command queue takes new request beats while the engine works
// and while a response beat waits to be popped. The memory needs no clearing after
// reset. Top level; depends on pal_pkg, pal_front, pal_cmdq and pal_back.
module positional_array_list_engine #(
   parameter int unsigned CAPACITY = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  pal_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output pal_pkg::rsp_type rsp_data
);
   import pal_pkg::*;

   logic    cq_push;
   logic    cq_full;
   cmd_type cq_in;
   logic    cq_pop;
   logic    cq_empty;
   cmd_type cq_out;

   pal_front u_front (
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cq_push  (cq_push),
      .cq_full  (cq_full),
      .cq_data  (cq_in)
   );

   pal_cmdq u_cmdq (
      .clock     (clock),
      .reset     (reset),
      .push      (cq_push),
      .full      (cq_full),
      .push_data (cq_in),
      .pop       (cq_pop),
      .empty     (cq_empty),
      .pop_data  (cq_out)
   );

   pal_back #(
      .CAPACITY (CAPACITY)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cq_empty  (cq_empty),
      .cq_pop    (cq_pop),
      .cq_data   (cq_out),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

/* tb/positional_array_list_engine_tb.sv */
// Self-checking testbench for the positional array list engine: queue-style driver and monitor,
// a list predictor kept in step with accepted beats, directed and random command streams.
// Depends on pal_pkg and positional_array_list_engine.
`timescale 1ns / 1ps

module positional_array_list_engine_tb;

   import pal_pkg::*;

   localparam int CAPACITY    = 32;
   localparam int HOLD_CYCLES = 200;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_push  = 1'b0;
   logic    req_full;
   req_type req_data  = '0;
   logic    rsp_empty;
   logic    rsp_pop   = 1'b0;
   rsp_type rsp_data;

   req_type cmd_backlog[$];
   rsp_type pending_results[$];
   rsp_type want_rsp;

   logic signed [DATA_W-1:0] list_store [0:CAPACITY-1];
   int list_len = 0;
   int gen_len  = 0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_token    = 0;
   int hold_served   = 0;
   int hold_left     = 0;

   int errors          = 0;
   int items_accepted  = 0;
   int results_checked = 0;
   int full_seen       = 0;
   int miss_seen       = 0;
   int peak_len        = 0;

   positional_array_list_engine #(
      .CAPACITY(CAPACITY)
   ) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type apply_list_command(input req_type r);
      rsp_type o;
      int      k;
      bit      hit;
      o   = '0;
      hit = 1'b0;
      o.status = ST_OK;
      case (r.command)
         CMD_INSERT: begin
            if (list_len >= CAPACITY) begin
               o.status = ST_FULL;
            end else if (r.position < 1 || r.position > list_len + 1) begin
               o.status = ST_MISS;
            end else begin
               for (k = list_len; k >= r.position; k--) list_store[k] = list_store[k-1];
               list_store[r.position-1] = r.value;
               list_len++;
            end
         end
         CMD_DELETE: begin
            if (r.position < 1 || r.position > list_len) begin
               o.status = ST_MISS;
            end else begin
               o.read_value = list_store[r.position-1];
               for (k = r.position; k < list_len; k++) list_store[k-1] = list_store[k];
               list_len--;
            end
         end
         CMD_GET: begin
            if (r.position < 1 || r.position > list_len) o.status = ST_MISS;
            else o.read_value = list_store[r.position-1];
         end
         CMD_LOCATE: begin
            o.status = ST_MISS;
            for (k = 0; k < list_len; k++) begin
               if (!hit && list_store[k] == r.value) begin
                  hit              = 1'b1;
                  o.found_position = POS_W'(k + 1);
                  o.status         = ST_OK;
               end
            end
         end
         CMD_CLEAR: begin
            list_len = 0;
         end
         default: begin
            o.status = ST_MISS;
         end
      endcase
      o.list_size = POS_W'(list_len);
      return o;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            pending_results.push_back(apply_list_command(req_data));
            items_accepted++;
            if (list_len > peak_len) peak_len = list_len;
         end
         if (!req_push || !req_full) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data <= cmd_backlog.pop_front();
               req_push <= 1'b1;
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   task automatic report_field(input string field, input longint want, input longint got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_pop   <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (pending_results.size() == 0) begin
               $display("%0t: response beat with nothing expected, actual %p", $time, rsp_data);
               errors++;
            end else begin
               want_rsp = pending_results.pop_front();
               report_field("status", want_rsp.status, rsp_data.status);
               report_field("read_value", want_rsp.read_value, rsp_data.read_value);
               report_field("found_position", want_rsp.found_position,
                            rsp_data.found_position);
               report_field("list_size", want_rsp.list_size, rsp_data.list_size);
               results_checked++;
               if (want_rsp.status == ST_FULL) full_seen++;
               if (want_rsp.status == ST_MISS) miss_seen++;
            end
         end
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_pop   <= 1'b0;
         end else if (hold_served != hold_token) begin
            hold_served <= hold_token;
            hold_left   <= HOLD_CYCLES;
            rsp_pop     <= 1'b0;
         end else begin
            rsp_pop <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic queue_item(input logic [CMD_W-1:0] cmd, input int pos,
                             input logic signed [DATA_W-1:0] val);
      req_type r;
      r.command  = cmd;
      r.position = POS_W'(pos);
      r.value    = val;
      cmd_backlog.push_back(r);
      case (cmd)
         CMD_INSERT: if (gen_len < CAPACITY && pos >= 1 && pos <= gen_len + 1) gen_len++;
         CMD_DELETE: if (pos >= 1 && pos <= gen_len) gen_len--;
         CMD_CLEAR:  gen_len = 0;
         default:    ;
      endcase
   endtask

   task automatic queue_random(input int count);
      int                       k;
      int                       roll;
      int                       ins_weight;
      int                       pos;
      logic [CMD_W-1:0]         cmd;
      logic signed [DATA_W-1:0] val;
      ins_weight = 50;
      for (k = 0; k < count; k++) begin
         if (k % 40 == 0) ins_weight = $urandom_range(20, 80);
         roll = $urandom_range(99);
         if (roll < 3) begin
            cmd = CMD_W'($urandom_range(7, 5));
         end else if (roll < 5) begin
            cmd = CMD_CLEAR;
         end else begin
            roll = $urandom_range(99);
            if (roll < ins_weight) cmd = CMD_INSERT;
            else if (roll < ins_weight + (100 - ins_weight) / 2) cmd = CMD_DELETE;
            else if (roll < ins_weight + 3 * (100 - ins_weight) / 4) cmd = CMD_GET;
            else cmd = CMD_LOCATE;
         end
         roll = $urandom_range(99);
         if (roll < 3) pos = $urandom_range(63);
         else if (roll < 15) pos = $urandom_range(33);
         else if (cmd == CMD_INSERT) pos = $urandom_range(gen_len + 1, 1);
         else pos = $urandom_range(gen_len > 0 ? gen_len : 1, 1);
         roll = $urandom_range(15);
         if ($urandom_range(99) < 40) val = $urandom;
         else if (roll == 0) val = 32'sh7FFF_FFFF;
         else if (roll == 1) val = 32'sh8000_0000;
         else if (roll == 2) val = -1;
         else val = roll - 3;
         queue_item(cmd, pos, val);
      end
   endtask

   task automatic wait_drained();
      while (cmd_backlog.size() != 0 || req_push || pending_results.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      int k;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 12;
      recv_idle_pct = 45;
      queue_item(CMD_GET, 1, 0);
      queue_item(CMD_DELETE, 0, 0);
      queue_item(CMD_LOCATE, 0, 0);
      queue_item(CMD_INSERT, 0, 5);
      queue_item(CMD_INSERT, 2, 5);
      queue_item(CMD_INSERT, 1, 32'sh7FFF_FFFF);
      queue_item(CMD_INSERT, 1, 32'sh8000_0000);
      queue_item(CMD_INSERT, 3, 0);
      queue_item(CMD_INSERT, 2, -1);
      queue_item(CMD_INSERT, 5, -1);
      queue_item(CMD_LOCATE, 63, -1);
      queue_item(CMD_LOCATE, 0, 12345);
      queue_item(CMD_GET, 0, 0);
      queue_item(CMD_GET, 5, 0);
      queue_item(CMD_GET, 6, 0);
      queue_item(CMD_GET, 63, 0);
      queue_item(CMD_DELETE, 1, 0);
      queue_item(CMD_DELETE, 4, 0);
      queue_item(CMD_DELETE, 4, 0);
      queue_item(3'd5, 1, 0);
      queue_item(3'd6, 2, -1);
      queue_item(3'd7, 63, 32'sh7FFF_FFFF);
      queue_item(CMD_CLEAR, 0, 0);
      queue_item(CMD_GET, 1, 0);

      // Fill the list to capacity, then hit the full and boundary cases.
      for (k = 0; k < CAPACITY; k++) queue_item(CMD_INSERT, $urandom_range(gen_len + 1, 1),
                                                $urandom);
      queue_item(CMD_INSERT, 0, 1);
      queue_item(CMD_INSERT, 33, 2);
      queue_item(CMD_GET, CAPACITY, 0);
      queue_item(CMD_GET, 33, 0);
      queue_item(CMD_DELETE, CAPACITY, 0);
      queue_item(CMD_CLEAR, 0, 0);

      queue_random(400);
      wait_drained();

      send_idle_pct = 45;
      recv_idle_pct = 12;
      queue_random(400);
      hold_token++;
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(450);
      wait_drained();

      repeat (100) @(posedge clock);
      $display("Checked %0d of %0d accepted beats; %0d full rejects, %0d misses.",
               results_checked, items_accepted, full_seen, miss_seen);
      $display("Longest list reached %0d entries; one long response stall was applied.",
               peak_len);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("[positional_array_list_engine] OK");
      end else begin
         $display("[positional_array_list_engine] ERROR");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timeout with %0d results outstanding.", pending_results.size());
      $display("[positional_array_list_engine] ERROR");
      $finish;
   end

endmodule
